// File: hw/rtl/max_heap_priority_queue_unit_defines.svh
// assertion macros for the heap priority queue rtl
// used by modules that check their own control logic, needs clk and rst_n in scope
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// checked only out of reset
`define HPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define HPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/hpq_pkg.sv
// shared types and constants for the heap priority queue
// no dependencies
`timescale 1ns / 1ps

package hpq_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = 6;
    localparam int CW    = 7;
    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] count_t;

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_EXTRACT = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_INCR    = 3'd3,
        CMD_DELETE  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_EMPTY = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_INDEX = 3'd3,
        STAT_LOWER = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EX_LOAD,
        S_PEEK,
        S_INCR,
        S_DEL,
        S_SH_RD,
        S_SH_WR,
        S_LAST_RD,
        S_LAST,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        key_t  wdata;
        addr_t raddr0;
        addr_t raddr1;
    } mem_req_t;

endpackage

// File: hw/rtl/hpq_intf.sv
// command and response channel interfaces for the heap priority queue
// no dependencies
`timescale 1ns / 1ps

interface hpq_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic signed [31:0] key_value;
    logic [5:0]        entry_index;

    modport source (output valid, command, key_value, entry_index, input ready);
    modport sink (input valid, command, key_value, entry_index, output ready);
endinterface

interface hpq_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] result_value;
    logic [2:0]        status;
    logic [6:0]        entry_count;

    modport source (output valid, result_value, status, entry_count, input ready);
    modport sink (input valid, result_value, status, entry_count, output ready);
endinterface

// File: hw/rtl/hpq_mem.sv
// heap key storage: one write port, two registered read ports
// depends on hpq_pkg
`timescale 1ns / 1ps

module hpq_mem (
    input  logic             clk,
    input  hpq_pkg::mem_req_t mreq,
    output hpq_pkg::key_t    rdata0,
    output hpq_pkg::key_t    rdata1
);

    hpq_pkg::key_t mem [hpq_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
        rdata0 <= mem[mreq.raddr0];
        rdata1 <= mem[mreq.raddr1];
    end

endmodule

// File: hw/rtl/hpq_ctrl.sv
// command sequencer: sift up, sift down and delete walks over the key memory
// depends on hpq_pkg, hpq_intf, hpq_mem and the defines header
`timescale 1ns / 1ps
`include "max_heap_priority_queue_unit_defines.svh"

module hpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  hpq_pkg::count_t cap_eff,
    hpq_cmd_if.sink        req,
    hpq_rsp_if.source      rsp
);

    hpq_pkg::state_t state_reg, state_next;
    hpq_pkg::key_t   key_reg, key_next;
    hpq_pkg::key_t   cur_reg, cur_next;
    hpq_pkg::key_t   val_reg, val_next;
    hpq_pkg::addr_t  pos_reg, pos_next;
    logic [2:0]      st_reg, st_next;
    hpq_pkg::count_t cnt_reg, cnt_next;

    logic            out_valid_reg, out_valid_next;
    hpq_pkg::key_t   out_val_reg, out_val_next;
    logic [2:0]      out_st_reg, out_st_next;
    hpq_pkg::count_t out_cnt_reg, out_cnt_next;

    hpq_pkg::mem_req_t mreq;
    hpq_pkg::key_t     rd0, rd1;

    hpq_pkg::addr_t  parent;
    hpq_pkg::count_t lchild, rchild, cnt_dec;
    logic            l_take, r_take;
    hpq_pkg::key_t   best;

    hpq_mem u_mem (
        .clk    (clk),
        .mreq   (mreq),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    assign parent = (pos_reg - hpq_pkg::addr_t'(1)) >> 1;
    assign lchild = {pos_reg, 1'b1};
    assign rchild = hpq_pkg::count_t'({pos_reg, 1'b1} + 8'd1);
    assign cnt_dec = cnt_reg - hpq_pkg::count_t'(1);

    // pick the larger child, left wins a tie
    always_comb
    begin
        l_take = (lchild < cnt_reg) && (rd0 > cur_reg);
        best   = l_take ? rd0 : cur_reg;
        r_take = (rchild < cnt_reg) && (rd1 > best);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpq_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        cur_reg     <= cur_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        st_reg      <= st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
        out_cnt_reg <= out_cnt_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        out_cnt_next   = out_cnt_reg;
        mreq           = '0;
        req.ready      = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            hpq_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    key_next = req.key_value;
                    val_next = '0;
                    st_next  = hpq_pkg::STAT_OK;
                    case (req.command) inside
                        hpq_pkg::CMD_INSERT:
                        begin
                            if (cnt_reg >= cap_eff)
                            begin
                                st_next    = hpq_pkg::STAT_FULL;
                                state_next = hpq_pkg::S_RESP;
                            end
                            else
                            begin
                                pos_next   = cnt_reg[hpq_pkg::AW-1:0];
                                cnt_next   = cnt_reg + hpq_pkg::count_t'(1);
                                cur_next   = req.key_value;
                                state_next = hpq_pkg::S_UP_RD;
                            end
                        end
                        hpq_pkg::CMD_EXTRACT, hpq_pkg::CMD_PEEK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = hpq_pkg::STAT_EMPTY;
                                state_next = hpq_pkg::S_RESP;
                            end
                            else
                            begin
                                mreq.raddr0 = '0;
                                mreq.raddr1 = cnt_dec[hpq_pkg::AW-1:0];
                                state_next  = (req.command == hpq_pkg::CMD_PEEK) ?
                                              hpq_pkg::S_PEEK : hpq_pkg::S_EX_LOAD;
                            end
                        end
                        hpq_pkg::CMD_INCR, hpq_pkg::CMD_DELETE:
                        begin
                            if ({1'b0, req.entry_index} >= cnt_reg)
                            begin
                                st_next    = hpq_pkg::STAT_INDEX;
                                state_next = hpq_pkg::S_RESP;
                            end
                            else
                            begin
                                mreq.raddr0 = req.entry_index;
                                pos_next    = req.entry_index;
                                state_next  = (req.command == hpq_pkg::CMD_INCR) ?
                                              hpq_pkg::S_INCR : hpq_pkg::S_DEL;
                            end
                        end
                        default:
                        begin
                            state_next = hpq_pkg::S_RESP;
                        end
                    endcase
                end
            end
            hpq_pkg::S_EX_LOAD:
            begin
                val_next   = rd0;
                cur_next   = rd1;
                cnt_next   = cnt_dec;
                pos_next   = '0;
                state_next = (cnt_dec == '0) ? hpq_pkg::S_RESP : hpq_pkg::S_DN_RD;
            end
            hpq_pkg::S_PEEK:
            begin
                val_next   = rd0;
                state_next = hpq_pkg::S_RESP;
            end
            hpq_pkg::S_INCR:
            begin
                if (rd0 > key_reg)
                begin
                    st_next    = hpq_pkg::STAT_LOWER;
                    state_next = hpq_pkg::S_RESP;
                end
                else
                begin
                    cur_next   = key_reg;
                    state_next = hpq_pkg::S_UP_RD;
                end
            end
            hpq_pkg::S_DEL:
            begin
                val_next   = rd0;
                state_next = hpq_pkg::S_SH_RD;
            end
            // ancestors of the deleted entry each move one level down
            hpq_pkg::S_SH_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = hpq_pkg::S_LAST_RD;
                end
                else
                begin
                    mreq.raddr0 = parent;
                    state_next  = hpq_pkg::S_SH_WR;
                end
            end
            hpq_pkg::S_SH_WR:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = pos_reg;
                mreq.wdata = rd0;
                pos_next   = parent;
                state_next = hpq_pkg::S_SH_RD;
            end
            hpq_pkg::S_LAST_RD:
            begin
                mreq.raddr0 = cnt_dec[hpq_pkg::AW-1:0];
                state_next  = hpq_pkg::S_LAST;
            end
            hpq_pkg::S_LAST:
            begin
                cur_next   = rd0;
                cnt_next   = cnt_dec;
                pos_next   = '0;
                state_next = (cnt_dec == '0) ? hpq_pkg::S_RESP : hpq_pkg::S_DN_RD;
            end
            // moving key stays in cur_reg, the hole walks toward the root
            hpq_pkg::S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = pos_reg;
                    mreq.wdata = cur_reg;
                    state_next = hpq_pkg::S_RESP;
                end
                else
                begin
                    mreq.raddr0 = parent;
                    state_next  = hpq_pkg::S_UP_CMP;
                end
            end
            hpq_pkg::S_UP_CMP:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = pos_reg;
                if (cur_reg > rd0)
                begin
                    mreq.wdata = rd0;
                    pos_next   = parent;
                    state_next = hpq_pkg::S_UP_RD;
                end
                else
                begin
                    mreq.wdata = cur_reg;
                    state_next = hpq_pkg::S_RESP;
                end
            end
            hpq_pkg::S_DN_RD:
            begin
                mreq.raddr0 = lchild[hpq_pkg::AW-1:0];
                mreq.raddr1 = rchild[hpq_pkg::AW-1:0];
                state_next  = hpq_pkg::S_DN_CMP;
            end
            hpq_pkg::S_DN_CMP:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = pos_reg;
                if (r_take)
                begin
                    mreq.wdata = rd1;
                    pos_next   = rchild[hpq_pkg::AW-1:0];
                    state_next = hpq_pkg::S_DN_RD;
                end
                else if (l_take)
                begin
                    mreq.wdata = rd0;
                    pos_next   = lchild[hpq_pkg::AW-1:0];
                    state_next = hpq_pkg::S_DN_RD;
                end
                else
                begin
                    mreq.wdata = cur_reg;
                    state_next = hpq_pkg::S_RESP;
                end
            end
            hpq_pkg::S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = val_reg;
                    out_st_next    = st_reg;
                    out_cnt_next   = cnt_reg;
                    state_next     = hpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hpq_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_val_reg;
    assign rsp.status       = out_st_reg;
    assign rsp.entry_count  = out_cnt_reg;

    `HPQ_ASSERT(a_cnt_bound, cnt_reg <= hpq_pkg::count_t'(hpq_pkg::DEPTH), "count above depth")
    `HPQ_ASSERT(a_cnt_step,
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + hpq_pkg::count_t'(1)) ||
        (cnt_reg + hpq_pkg::count_t'(1) == $past(cnt_reg)), "count jumped")
    `HPQ_ASSERT(a_wr_in_heap, mreq.we |-> ({1'b0, mreq.waddr} < cnt_reg), "write beyond heap")
    `HPQ_ASSERT(a_rsp_one, (state_reg == hpq_pkg::S_RESP && !out_valid_reg) |=> out_valid_reg, "response not loaded")

endmodule

// File: hw/rtl/max_heap_priority_queue_unit.sv
// top level of the heap priority queue: capacity register on apb and the sequencer
// depends on hpq_pkg, hpq_intf, hpq_ctrl
//
// channel | role | transfer
// req     | sink   | command, key_value, entry_index
// rsp     | source | result_value, status, entry_count
// apb     | slave  | capacity_limit at byte 0
//
// one command at a time; its length is set by the walk over the key memory, one heap level at a time:
// rejects, unknown codes and peek make no walk, and a delete deep in a full heap makes the longest.
// reset clears the count and the capacity (to 64); key memory needs no clearing.
// a result waits in the output register; the next command is taken while it waits.

`timescale 1ns / 1ps

module max_heap_priority_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    hpq_cmd_if.sink     req,
    hpq_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    hpq_pkg::count_t cap_reg;
    hpq_pkg::count_t cap_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= hpq_pkg::count_t'(hpq_pkg::DEPTH);
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            cap_reg <= pwdata[hpq_pkg::CW-1:0];
        end
    end

    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? 32'd0 : {25'd0, cap_reg};
    assign cap_eff = (cap_reg > hpq_pkg::count_t'(hpq_pkg::DEPTH)) ?
                     hpq_pkg::count_t'(hpq_pkg::DEPTH) : cap_reg;

    hpq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cap_eff (cap_eff),
        .req     (req),
        .rsp     (rsp)
    );

endmodule
